/* rtl/core/ccs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and character constants for the C comment stripper.
// Used by the front end, the back end and the top level.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Hard cap on the comment buffer, and the width of a fill count up to it
    localparam int STORE_SLOTS = 32;
    localparam int CNT_W       = 6;

    typedef enum logic [0:0] {
        CMD_BYTES  = 1'b0,
        CMD_REPLAY = 1'b1
    } t_cmd_kind;

    // One queued job for the back end: one or two literal bytes, or a replay
    typedef struct packed {
        t_cmd_kind        kind;
        logic             two;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_cmd;

endpackage

/* rtl/core/ccs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ccs_fifo.sv */
`timescale 1ns / 1ps
// Two-entry register queue between the front end and the back end.
// No package dependencies.
module ccs_fifo #(
    parameter int WIDTH = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_slot[r_rptr];

endmodule

/* rtl/core/ccs_front.sv */
`timescale 1ns / 1ps
// Front end: accepts source bytes, runs the comment scanner, fills the comment
// buffer and queues output jobs. Depends on ccs_pkg.
module ccs_front #(
    parameter int LIMIT = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_char,
    input  logic                     i_eof,
    input  logic                     i_q_full,
    output logic                     o_push,
    output ccs_pkg::t_cmd            o_cmd,
    output logic                     o_we,
    output logic [$clog2(LIMIT)-1:0] o_waddr,
    output logic [7:0]               o_wdata,
    input  logic                     i_replay_done,
    output logic                     o_busy
);

    localparam int IDX_W = $clog2(LIMIT);

    typedef enum logic [3:0] {
        M_TEXT,
        M_SLASH,
        M_BLOCK,
        M_BLOCK_STAR,
        M_LINE,
        M_STR,
        M_STR_ESC,
        M_CHR,
        M_CHR_ESC
    } t_mode;

    t_mode                       r_mode, n_mode;
    logic [ccs_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_ovf, n_ovf;
    logic                        r_busy, n_busy;
    logic                        accept;
    logic                        room;
    t_mode                       quote_mode;

    assign o_ready = !i_q_full && !r_busy;
    assign accept  = i_valid && o_ready;
    assign room    = (r_cnt < ccs_pkg::CNT_W'(LIMIT));
    assign o_waddr = r_cnt[IDX_W-1:0];
    assign o_wdata = i_char;
    assign o_busy  = r_busy;

    // Mode after a byte that is passed through from plain text
    always_comb begin
        if (i_char == ccs_pkg::CH_DQUOTE) begin
            quote_mode = M_STR;
        end else if (i_char == ccs_pkg::CH_SQUOTE) begin
            quote_mode = M_CHR;
        end else begin
            quote_mode = M_TEXT;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_ovf  = r_ovf;
        n_busy = r_busy;
        o_push = 1'b0;
        o_we   = 1'b0;
        o_cmd  = '0;
        o_cmd.kind = ccs_pkg::CMD_BYTES;
        o_cmd.b0   = i_char;

        if (i_replay_done) begin
            n_busy = 1'b0;
        end

        if (accept) begin
            if (i_eof) begin
                if (r_mode == M_SLASH) begin
                    o_push   = 1'b1;
                    o_cmd.b0 = ccs_pkg::CH_SLASH;
                end else if ((r_mode == M_BLOCK || r_mode == M_BLOCK_STAR)
                             && r_cnt != '0) begin
                    o_push      = 1'b1;
                    o_cmd.kind  = ccs_pkg::CMD_REPLAY;
                    o_cmd.count = r_cnt;
                    o_cmd.ovf   = r_ovf;
                    n_busy      = 1'b1;
                end
                n_mode = M_TEXT;
                n_cnt  = '0;
                n_ovf  = 1'b0;
            end else begin
                case (r_mode)
                    M_TEXT: begin
                        if (i_char == ccs_pkg::CH_SLASH) begin
                            n_mode = M_SLASH;
                        end else begin
                            o_push = 1'b1;
                            n_mode = quote_mode;
                        end
                    end
                    M_SLASH: begin
                        if (i_char == ccs_pkg::CH_STAR) begin
                            // slash and star sit implicitly in slots zero and one
                            n_cnt  = ccs_pkg::CNT_W'(2);
                            n_ovf  = 1'b0;
                            n_mode = M_BLOCK;
                        end else if (i_char == ccs_pkg::CH_SLASH) begin
                            n_mode = M_LINE;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd.two = 1'b1;
                            o_cmd.b0  = ccs_pkg::CH_SLASH;
                            o_cmd.b1  = i_char;
                            n_mode    = quote_mode;
                        end
                    end
                    M_LINE: begin
                        if (i_char == ccs_pkg::CH_LF || i_char == ccs_pkg::CH_CR) begin
                            o_push = 1'b1;
                            n_mode = M_TEXT;
                        end
                    end
                    M_BLOCK, M_BLOCK_STAR: begin
                        if (r_mode == M_BLOCK_STAR && i_char == ccs_pkg::CH_SLASH) begin
                            o_push   = 1'b1;
                            o_cmd.b0 = ccs_pkg::CH_SPACE;
                            n_cnt    = '0;
                            n_ovf    = 1'b0;
                            n_mode   = M_TEXT;
                        end else begin
                            if (room) begin
                                o_we  = 1'b1;
                                n_cnt = r_cnt + ccs_pkg::CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_mode = (i_char == ccs_pkg::CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
                        end
                    end
                    M_STR: begin
                        o_push = 1'b1;
                        if (i_char == ccs_pkg::CH_BSLASH) begin
                            n_mode = M_STR_ESC;
                        end else if (i_char == ccs_pkg::CH_DQUOTE) begin
                            n_mode = M_TEXT;
                        end
                    end
                    M_STR_ESC: begin
                        o_push = 1'b1;
                        n_mode = M_STR;
                    end
                    M_CHR: begin
                        o_push = 1'b1;
                        if (i_char == ccs_pkg::CH_BSLASH) begin
                            n_mode = M_CHR_ESC;
                        end else if (i_char == ccs_pkg::CH_SQUOTE) begin
                            n_mode = M_TEXT;
                        end
                    end
                    M_CHR_ESC: begin
                        o_push = 1'b1;
                        n_mode = M_CHR;
                    end
                    default: begin
                        n_mode = M_TEXT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TEXT;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_busy <= n_busy;
        end
    end

endmodule

/* rtl/core/ccs_back.sv */
`timescale 1ns / 1ps
// Back end: pops queued jobs, emits literal bytes and replays the comment
// buffer into the output register. Depends on ccs_pkg.
module ccs_back #(
    parameter int LIMIT = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  ccs_pkg::t_cmd            i_cmd,
    output logic                     o_pop,
    output logic [$clog2(LIMIT)-1:0] o_raddr,
    input  logic [7:0]               i_rdata,
    output logic                     o_replay_done,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_char,
    output logic                     o_last,
    output logic                     o_ovf
);

    localparam int IDX_W = $clog2(LIMIT);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SECOND,
        B_REPLAY
    } t_bstate;

    t_bstate                   r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_out_char, n_out_char;
    logic                      r_out_last, n_out_last;
    logic                      r_out_ovf, n_out_ovf;
    logic [7:0]                r_b1, n_b1;
    logic [ccs_pkg::CNT_W-1:0] r_rcnt, n_rcnt;
    logic                      r_rovf, n_rovf;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_addr_ok, n_addr_ok;
    logic                      out_free;
    logic                      head_slot;
    logic [7:0]                rp_char;
    logic                      rp_ok;
    logic                      rp_last;

    assign out_free  = !r_out_valid || i_ready;
    assign head_slot = (ccs_pkg::CNT_W'(r_idx) < ccs_pkg::CNT_W'(2));
    assign rp_char   = head_slot ? ((r_idx == '0) ? ccs_pkg::CH_SLASH : ccs_pkg::CH_STAR)
                                 : i_rdata;
    // RAM data is good in the cycle after the address settles
    assign rp_ok     = head_slot || r_addr_ok;
    assign rp_last   = (ccs_pkg::CNT_W'(r_idx) + ccs_pkg::CNT_W'(1) == r_rcnt);
    assign o_raddr   = r_idx;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_out_char    = r_out_char;
        n_out_last    = r_out_last;
        n_out_ovf     = r_out_ovf;
        n_b1          = r_b1;
        n_rcnt        = r_rcnt;
        n_rovf        = r_rovf;
        n_idx         = r_idx;
        n_addr_ok     = r_addr_ok;
        o_pop         = 1'b0;
        o_replay_done = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == ccs_pkg::CMD_BYTES) begin
                        n_out_valid = 1'b1;
                        n_out_char  = i_cmd.b0;
                        n_out_last  = !i_cmd.two;
                        n_out_ovf   = 1'b0;
                        n_b1        = i_cmd.b1;
                        if (i_cmd.two) begin
                            n_state = B_SECOND;
                        end
                    end else begin
                        n_rcnt    = i_cmd.count;
                        n_rovf    = i_cmd.ovf;
                        n_idx     = '0;
                        n_addr_ok = 1'b0;
                        n_state   = B_REPLAY;
                    end
                end
            end
            B_SECOND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_b1;
                    n_out_last  = 1'b1;
                    n_out_ovf   = 1'b0;
                    n_state     = B_IDLE;
                end
            end
            B_REPLAY: begin
                if (out_free && rp_ok) begin
                    n_out_valid = 1'b1;
                    n_out_char  = rp_char;
                    n_out_last  = rp_last;
                    n_out_ovf   = r_rovf;
                    if (rp_last) begin
                        o_replay_done = 1'b1;
                        n_state       = B_IDLE;
                    end else begin
                        n_idx     = r_idx + IDX_W'(1);
                        n_addr_ok = 1'b0;
                    end
                end else begin
                    n_addr_ok = 1'b1;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_addr_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_addr_ok   <= n_addr_ok;
        end
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
        r_b1       <= n_b1;
        r_rcnt     <= n_rcnt;
        r_rovf     <= n_rovf;
        r_idx      <= n_idx;
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;
    assign o_ovf   = r_out_ovf;

endmodule

/* rtl/core/c_comment_stripper_unit.sv */
`timescale 1ns / 1ps
// Top level of the C comment stripper: front end, job queue, back end and
// comment buffer RAM. Depends on ccs_pkg, ccs_front, ccs_fifo, ccs_back, ccs_ram.
//
// Usage:
//   Slave stream carries one source byte per transaction in s_tdata; s_tuser
//   set marks end of file (the byte is then ignored). Master stream carries one
//   output byte per transaction in m_tdata; m_tlast marks the last byte caused
//   by one input transaction; m_tuser is set on replayed comment bytes when the
//   unterminated comment was longer than the buffer.
//   A passed byte goes into the job queue and then the output register before
//   it is valid on the master side. Throughput: one input byte per cycle while
//   the master side is ready and each input produces at most one output byte;
//   a slash followed by an ordinary byte yields two output bytes and holds the
//   queue for the second. At end of file inside an unclosed block comment the
//   buffer is replayed: the first two bytes are the fixed slash and star, every
//   further byte waits for the registered RAM read. The slave side stalls
//   during the replay so the buffer can not be refilled early.
//   Reset clears scanner state, the queue and the output register; the RAM
//   needs no clearing. When the master side stalls, the output register and the
//   two-entry queue fill and then the slave side is held off.
module c_comment_stripper_unit #(
    parameter int COMMENT_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_char
    input  logic [0:0] i_s_tuser,   // [0] end_of_input
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tlast,
    output logic [0:0] o_m_tuser    // [0] overflowed
);

    localparam int LIMIT = (COMMENT_DEPTH < ccs_pkg::STORE_SLOTS) ? COMMENT_DEPTH
                                                                   : ccs_pkg::STORE_SLOTS;
    localparam int IDX_W = $clog2(LIMIT);
    localparam int CMD_W = $bits(ccs_pkg::t_cmd);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    ccs_pkg::t_cmd      push_cmd;
    ccs_pkg::t_cmd      head_cmd;
    logic [CMD_W-1:0]   head_bits;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [7:0]         ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [7:0]         ram_rdata;
    logic               replay_done;
    logic               busy;

    ccs_front #(.LIMIT(LIMIT)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_char        (i_s_tdata),
        .i_eof         (i_s_tuser[0]),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd),
        .o_we          (ram_we),
        .o_waddr       (ram_waddr),
        .o_wdata       (ram_wdata),
        .i_replay_done (replay_done),
        .o_busy        (busy)
    );

    ccs_fifo #(.WIDTH(CMD_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_bits)
    );

    assign head_cmd = ccs_pkg::t_cmd'(head_bits);

    ccs_ram #(.WIDTH(8), .DEPTH(LIMIT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ccs_back #(.LIMIT(LIMIT)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .o_raddr       (ram_raddr),
        .i_rdata       (ram_rdata),
        .o_replay_done (replay_done),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_char        (o_m_tdata),
        .o_last        (o_m_tlast),
        .o_ovf         (o_m_tuser[0])
    );

    // The buffer must not be written while a replay still reads it
    a_no_write_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !ram_we)
        else $error("comment buffer written during replay");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job queue overrun");

    a_done_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        replay_done |-> busy)
        else $error("replay finished without a pending replay");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        replay_done |=> (o_m_tvalid && o_m_tlast))
        else $error("replay end not marked on output");

endmodule
